@@ rtl/core/cpb_pkg.sv @@
// ============================================================================
// cpb_pkg: shared types and constants of the color palette builder
// Sizes of the palette, the request token that runs along the cell chain,
// the write port into the cells, status codes and the BGR555 packing.
// ============================================================================
`default_nettype none

package cpb_pkg;

    // Palette size and derived widths.
    localparam int ENTRIES  = 256;
    localparam int CELL_W   = $clog2(ENTRIES);
    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int READ_W   = 8;
    localparam int CMP_W    = (CNT_W > READ_W) ? CNT_W : READ_W;
    localparam int COLOR_W  = 24;
    localparam int BGR_W    = 15;

    typedef logic [COLOR_W-1:0] color_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_FOUND    = 2'd0,
        STAT_INSERTED = 2'd1,
        STAT_FULL     = 2'd2,
        STAT_BEYOND   = 2'd3
    } status_t;

    // Controller states.
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } ctrl_state_t;

    // Request token handed from cell to cell.
    typedef struct packed {
        logic              active;
        logic              command;
        color_t            key;
        logic [READ_W-1:0] idx;
        logic              found;
        logic [CELL_W-1:0] slot;
        color_t            color;
    } query_t;

    // Write into one cell of the chain.
    typedef struct packed {
        logic              en;
        logic [CELL_W-1:0] idx;
        color_t            data;
    } write_t;

    // Drop the low three bits of each channel; blue high, red low.
    function automatic logic [BGR_W-1:0] to_bgr555(input color_t c);
        to_bgr555 = {c[7:3], c[15:11], c[23:19]};
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/cpb_cell.sv @@
// ============================================================================
// cpb_cell: one palette entry of the cell chain
// Holds one stored color, checks the passing request against it and hands
// the request on to the next cell through its stage register.
// ============================================================================
`default_nettype none

module cpb_cell (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [cpb_pkg::CELL_W-1:0]  cell_index,
    input  wire logic [cpb_pkg::CNT_W-1:0]   count,
    input  wire cpb_pkg::write_t             wr,
    input  wire cpb_pkg::query_t             token_in,
    output cpb_pkg::query_t                  token_out
);

    cpb_pkg::color_t entry_reg;
    logic            active_reg;
    cpb_pkg::query_t payload_reg;
    cpb_pkg::query_t payload_next;
    logic            occupied;
    logic            add_hit;
    logic            read_hit;

    // The stored color is written when the controller appends it here.
    always_ff @(posedge clk)
    begin
        if (wr.en && (wr.idx == cell_index))
        begin
            entry_reg <= wr.data;
        end
    end

    // Only entries below the fill count take part in a search or a read.
    assign occupied = cpb_pkg::CMP_W'(cell_index) < cpb_pkg::CMP_W'(count);

    assign add_hit  = token_in.active && !token_in.command && !token_in.found
                      && occupied && (entry_reg == token_in.key);
    assign read_hit = token_in.active && token_in.command && occupied
                      && (cpb_pkg::CMP_W'(cell_index) == cpb_pkg::CMP_W'(token_in.idx));

    // The first hit along the chain marks the request and records the entry.
    always_comb
    begin
        payload_next = token_in;
        if (add_hit || read_hit)
        begin
            payload_next.found = 1'b1;
            payload_next.slot  = cell_index;
            payload_next.color = entry_reg;
        end
    end

    // Stage register toward the next cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= token_in.active;
        end
    end

    always_ff @(posedge clk)
    begin
        payload_reg <= payload_next;
    end

    always_comb
    begin
        token_out        = payload_reg;
        token_out.active = active_reg;
    end

endmodule

`default_nettype wire

@@ rtl/core/cpb_ctrl.sv @@
// ============================================================================
// cpb_ctrl: command controller of the color palette builder
// Tracks the request in flight, keeps the fill count, appends new colors
// and forms the result when the request leaves the end of the chain.
// ============================================================================
`default_nettype none

module cpb_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire cpb_pkg::query_t               tail,
    output logic [cpb_pkg::CNT_W-1:0]          count,
    output cpb_pkg::write_t                    wr,
    output logic                               done,
    output logic [7:0]                         slot,
    output logic [cpb_pkg::BGR_W-1:0]          color_bgr555,
    output logic [1:0]                         status,
    output logic [8:0]                         entries_used
);

    cpb_pkg::ctrl_state_t          state_reg;
    cpb_pkg::ctrl_state_t          state_next;
    logic [cpb_pkg::CNT_W-1:0]     count_reg;
    logic [cpb_pkg::CNT_W-1:0]     count_next;
    logic                          done_reg;
    logic                          done_next;
    logic [7:0]                    slot_reg;
    logic [7:0]                    slot_next;
    logic [cpb_pkg::BGR_W-1:0]     color_reg;
    logic [cpb_pkg::BGR_W-1:0]     color_next;
    cpb_pkg::status_t              status_reg;
    cpb_pkg::status_t              status_next;
    logic                          finish;
    logic                          table_full;

    assign finish     = (state_reg == cpb_pkg::ST_RUN) && tail.active;
    assign table_full = (count_reg == cpb_pkg::CNT_W'(cpb_pkg::ENTRIES));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cpb_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = cpb_pkg::ST_RUN;
                end
            end
            cpb_pkg::ST_RUN:
            begin
                if (tail.active)
                begin
                    state_next = cpb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cpb_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb
    begin
        unique case (state_reg)
            cpb_pkg::ST_IDLE: busy = 1'b0;
            cpb_pkg::ST_RUN:  busy = 1'b1;
            default:          busy = 1'b1;
        endcase
    end

    // Result and append when the request leaves the chain.
    always_comb
    begin
        done_next   = 1'b0;
        slot_next   = slot_reg;
        color_next  = color_reg;
        status_next = status_reg;
        count_next  = count_reg;
        wr          = '0;
        if (finish)
        begin
            done_next = 1'b1;
            if (tail.command)
            begin
                slot_next = tail.idx;
                if (tail.found)
                begin
                    color_next  = cpb_pkg::to_bgr555(tail.color);
                    status_next = cpb_pkg::STAT_FOUND;
                end
                else
                begin
                    color_next  = '0;
                    status_next = cpb_pkg::STAT_BEYOND;
                end
            end
            else if (tail.found)
            begin
                slot_next   = 8'(tail.slot);
                color_next  = cpb_pkg::to_bgr555(tail.key);
                status_next = cpb_pkg::STAT_FOUND;
            end
            else if (table_full)
            begin
                slot_next   = '0;
                color_next  = '0;
                status_next = cpb_pkg::STAT_FULL;
            end
            else
            begin
                slot_next   = 8'(count_reg);
                color_next  = cpb_pkg::to_bgr555(tail.key);
                status_next = cpb_pkg::STAT_INSERTED;
                count_next  = count_reg + cpb_pkg::CNT_W'(1);
                wr.en       = 1'b1;
                wr.idx      = cpb_pkg::CELL_W'(count_reg);
                wr.data     = tail.key;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cpb_pkg::ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        slot_reg   <= slot_next;
        color_reg  <= color_next;
        status_reg <= status_next;
    end

    assign count        = count_reg;
    assign done         = done_reg;
    assign slot         = slot_reg;
    assign color_bgr555 = color_reg;
    assign status       = status_reg;
    assign entries_used = 9'(count_reg);

`ifndef SYNTHESIS
    // A result is only produced right after a request was in flight.
    a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg) == cpb_pkg::ST_RUN)
        else $error("result strobe without a request in flight");

    // The fill count never passes the palette size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cpb_pkg::CNT_W'(cpb_pkg::ENTRIES))
        else $error("fill count beyond palette size");

    // An inserted color grows the count by exactly one.
    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (status_reg == cpb_pkg::STAT_INSERTED)
        |-> count_reg == $past(count_reg) + cpb_pkg::CNT_W'(1))
        else $error("insert did not advance the fill count");

    // A request reaches the end of the chain only while one is in flight.
    a_tail_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        tail.active |-> state_reg == cpb_pkg::ST_RUN)
        else $error("request left the chain while idle");
`endif

endmodule

`default_nettype wire

@@ rtl/core/color_palette_builder.sv @@
// ============================================================================
// color_palette_builder: palette of distinct RGB colors with BGR555 readout
// Adds colors to a table of distinct entries and reads entries back as
// BGR555, using a chain of entry cells that a request walks through.
// ============================================================================
//
//  Channel   Handshake            Signals
//  -------   ------------------   ---------------------------------------------
//  request   start && !busy       command, red, green, blue, read_index
//  result    done (one cycle)     slot, color_bgr555, status, entries_used
//
// One request at a time: it walks the chain of ENTRIES cells, one cell per
// cycle, through the stage register of each cell, and the controller then
// registers done; busy is high from acceptance until done rises. A new
// request may be given in the cycle that done is high.
// Reset empties the palette at once by clearing the fill count.
// The done strobe is high for exactly one cycle; the receiver cannot stall it.
`default_nettype none

module color_palette_builder (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          command,
    input  wire logic [7:0]                    red,
    input  wire logic [7:0]                    green,
    input  wire logic [7:0]                    blue,
    input  wire logic [7:0]                    read_index,
    output logic                               done,
    output logic [7:0]                         slot,
    output logic [cpb_pkg::BGR_W-1:0]          color_bgr555,
    output logic [1:0]                         status,
    output logic [8:0]                         entries_used
);

    cpb_pkg::query_t             chain [0:cpb_pkg::ENTRIES];
    cpb_pkg::write_t             wr;
    logic [cpb_pkg::CNT_W-1:0]   count;

    // New request enters the head of the chain when accepted.
    always_comb
    begin
        chain[0].active  = start && !busy;
        chain[0].command = command;
        chain[0].key     = {red, green, blue};
        chain[0].idx     = read_index;
        chain[0].found   = 1'b0;
        chain[0].slot    = '0;
        chain[0].color   = '0;
    end

    // Row of entry cells.
    for (genvar i = 0; i < cpb_pkg::ENTRIES; i++)
    begin : g_cell
        cpb_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_index (cpb_pkg::CELL_W'(i)),
            .count      (count),
            .wr         (wr),
            .token_in   (chain[i]),
            .token_out  (chain[i+1])
        );
    end

    // Controller and result registers.
    cpb_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .tail         (chain[cpb_pkg::ENTRIES]),
        .count        (count),
        .wr           (wr),
        .done         (done),
        .slot         (slot),
        .color_bgr555 (color_bgr555),
        .status       (status),
        .entries_used (entries_used)
    );

endmodule

`default_nettype wire
